FILE: src/dpnc_pkg.sv
// Shared types and constants for the depth pixel noise and confidence block.
// Beat payload structs, pixel class codes, register indexes, counter limit.
// No dependencies.
`default_nettype none

package dpnc_pkg;

	localparam int unsigned MAX_FRAME_PIXELS = 4194304;
	localparam int unsigned CNT_W            = 23;
	localparam int unsigned CNT_MAX          = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] CNT_LIMIT   =
		CNT_W'((MAX_FRAME_PIXELS < CNT_MAX) ? MAX_FRAME_PIXELS : CNT_MAX);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;
	localparam logic [16:0] CONF_ONE   = 17'd65536;

	typedef enum logic [2:0] {
		CLS_VALID     = 3'd0,
		CLS_NONFINITE = 3'd1,
		CLS_ZERO      = 3'd2,
		CLS_BELOW_MIN = 3'd3,
		CLS_ABOVE_MAX = 3'd4
	} pixel_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DEPTH    = 3'd0,
		REG_MAX_DEPTH    = 3'd1,
		REG_NOISE_OFFSET = 3'd2,
		REG_NOISE_GAIN   = 3'd3,
		REG_VAR_REF      = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [23:0] depth_sample;
		logic               not_finite;
		logic               first_pixel;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]       pixel_class;
		logic [22:0]      clean_depth;
		logic [47:0]      noise_variance;
		logic [16:0]      confidence;
		logic [CNT_W-1:0] pixels_seen;
		logic [CNT_W-1:0] valid_count;
		logic [CNT_W-1:0] nonfinite_count;
		logic [CNT_W-1:0] zero_count;
		logic [CNT_W-1:0] below_min_count;
		logic [CNT_W-1:0] above_max_count;
	} out_beat_t;

	// divider handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: src/depth_pixel_noise_confidence.sv
// Depth pixel noise and confidence: top level with sequencer, counters and config.
// Instantiates dpnc_mul and dpnc_div; depends on dpnc_pkg.
// One pixel at a time: a valid pixel steps through S_SQ, S_GLO, S_GHI, S_SIG, S_VAR, S_DIV,
// S_WAIT and S_OUT, with four passes through the shared 24x24 multiplier and the 17-step
// one-bit-per-cycle divider for confidence; other classes go straight to S_OUT.
// in_ready is high only while idle. The result beat sits in an output register, so a held
// result stalls the next pixel only once that pixel finishes. Frame counters saturate
// at the smaller of MAX_FRAME_PIXELS and 2^23-1 and are reported with every result beat.
`default_nettype none

module depth_pixel_noise_confidence (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire dpnc_pkg::in_beat_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output dpnc_pkg::out_beat_t                     out_data,
	input  wire logic                               cfg_wen,
	input  wire logic [dpnc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dpnc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_GLO, S_GHI, S_SIG, S_VAR, S_DIV, S_WAIT, S_OUT
	} state_t;

	localparam int unsigned CW = dpnc_pkg::CNT_W;

	state_t  state_q;

	// configuration
	logic [22:0] min_depth_q;
	logic [22:0] max_depth_q;
	logic [22:0] noise_offset_q;
	logic [15:0] noise_gain_q;
	logic [47:0] var_ref_q;

	// frame counters
	logic [CW-1:0] seen_q, valid_q, nonfinite_q, zero_q, below_q, above_q;

	// per-pixel datapath
	logic [2:0]  class_q;
	logic [22:0] depth_q;
	logic [45:0] sq_q;
	logic [39:0] lo_q;
	logic [23:0] sigma_q;
	logic [47:0] var_q;
	logic [16:0] conf_q;
	logic        out_valid_q;
	dpnc_pkg::out_beat_t out_q;

	logic [23:0] mul_a, mul_b;
	logic [47:0] mul_p;
	dpnc_pkg::div_ctrl_t div_ctrl;
	dpnc_pkg::div_stat_t div_stat;
	logic [16:0] div_quot;

	logic        accept;
	logic        slot_free;
	logic [2:0]  cls;
	logic signed [24:0] d_ext;
	logic [61:0] gain_prod;
	logic [62:0] gain_rnd;
	logic [31:0] sigma_sum;
	logic [23:0] sigma_sat;

	function automatic logic [CW-1:0] bump(input logic [CW-1:0] c, input logic clr,
		input logic hit);
		logic [CW-1:0] base;
		base = clr ? '0 : c;
		if (hit && (base < dpnc_pkg::CNT_LIMIT)) begin
			return base + CW'(1);
		end
		return base;
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// priority classification
	always_comb begin
		d_ext = {in_data.depth_sample[23], in_data.depth_sample};
		if (in_data.not_finite) begin
			cls = dpnc_pkg::CLS_NONFINITE;
		end else if (d_ext == 25'sd0) begin
			cls = dpnc_pkg::CLS_ZERO;
		end else if (d_ext < $signed({2'b00, min_depth_q})) begin
			cls = dpnc_pkg::CLS_BELOW_MIN;
		end else if (d_ext > $signed({2'b00, max_depth_q})) begin
			cls = dpnc_pkg::CLS_ABOVE_MAX;
		end else begin
			cls = dpnc_pkg::CLS_VALID;
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_SQ: begin
				mul_a = {1'b0, depth_q};
				mul_b = {1'b0, depth_q};
			end
			S_GLO: begin
				mul_a = mul_p[23:0];
				mul_b = {8'b0, noise_gain_q};
			end
			S_GHI: begin
				mul_a = {2'b0, sq_q[45:24]};
				mul_b = {8'b0, noise_gain_q};
			end
			S_VAR: begin
				mul_a = sigma_q;
				mul_b = sigma_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sigma = offset + round(sq*gain / 2^32), saturated; high partial product in mul_p
	always_comb begin
		gain_prod = {mul_p[37:0], 24'b0} + {22'b0, lo_q};
		gain_rnd  = {1'b0, gain_prod} + 63'h0000_0000_8000_0000;
		sigma_sum = {9'b0, noise_offset_q} + {1'b0, gain_rnd[62:32]};
		sigma_sat = (|sigma_sum[31:24]) ? 24'hFF_FFFF : sigma_sum[23:0];
	end

	assign div_ctrl.start = (state_q == S_DIV);

	dpnc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	dpnc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (div_ctrl),
		.ref_val (var_ref_q),
		.var_val (mul_p),
		.stat    (div_stat),
		.quot    (div_quot)
	);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cls == dpnc_pkg::CLS_VALID) ? S_SQ : S_OUT;
					end
				end
				S_SQ:  state_q <= S_GLO;
				S_GLO: state_q <= S_GHI;
				S_GHI: state_q <= S_SIG;
				S_SIG: state_q <= S_VAR;
				S_VAR: state_q <= S_DIV;
				S_DIV: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// frame counters, updated on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			valid_q     <= '0;
			nonfinite_q <= '0;
			zero_q      <= '0;
			below_q     <= '0;
			above_q     <= '0;
		end else if (accept) begin
			seen_q      <= bump(seen_q, in_data.first_pixel, 1'b1);
			valid_q     <= bump(valid_q, in_data.first_pixel, cls == dpnc_pkg::CLS_VALID);
			nonfinite_q <= bump(nonfinite_q, in_data.first_pixel,
				cls == dpnc_pkg::CLS_NONFINITE);
			zero_q      <= bump(zero_q, in_data.first_pixel, cls == dpnc_pkg::CLS_ZERO);
			below_q     <= bump(below_q, in_data.first_pixel,
				cls == dpnc_pkg::CLS_BELOW_MIN);
			above_q     <= bump(above_q, in_data.first_pixel,
				cls == dpnc_pkg::CLS_ABOVE_MAX);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_depth_q    <= 23'd6554;
			max_depth_q    <= 23'd655360;
			noise_offset_q <= 23'd66;
			noise_gain_q   <= 16'd164;
			var_ref_q      <= 48'd42949673;
		end else if (cfg_wen) begin
			case (cfg_index)
				dpnc_pkg::REG_MIN_DEPTH:    min_depth_q    <= cfg_data[22:0];
				dpnc_pkg::REG_MAX_DEPTH:    max_depth_q    <= cfg_data[22:0];
				dpnc_pkg::REG_NOISE_OFFSET: noise_offset_q <= cfg_data[22:0];
				dpnc_pkg::REG_NOISE_GAIN:   noise_gain_q   <= cfg_data[15:0];
				dpnc_pkg::REG_VAR_REF:      var_ref_q      <= cfg_data[47:0];
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					class_q <= cls;
					depth_q <= (cls == dpnc_pkg::CLS_VALID) ? in_data.depth_sample[22:0] : '0;
					var_q   <= '0;
					conf_q  <= '0;
				end
			end
			S_GLO: sq_q    <= mul_p[45:0];
			S_GHI: lo_q    <= mul_p[39:0];
			S_SIG: sigma_q <= sigma_sat;
			S_DIV: var_q   <= mul_p;
			S_WAIT: begin
				// a zero reference gives zero confidence
				if (div_stat.done) begin
					conf_q <= (var_ref_q == '0) ? '0 : div_quot;
				end
			end
			S_OUT: begin
				if (slot_free) begin
					out_q.pixel_class     <= class_q;
					out_q.clean_depth     <= depth_q;
					out_q.noise_variance  <= var_q;
					out_q.confidence      <= conf_q;
					out_q.pixels_seen     <= seen_q;
					out_q.valid_count     <= valid_q;
					out_q.nonfinite_count <= nonfinite_q;
					out_q.zero_count      <= zero_q;
					out_q.below_min_count <= below_q;
					out_q.above_max_count <= above_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: src/dpnc_mul.sv
// Shared 24x24 unsigned multiplier with registered product.
// Used in turn for depth squared, both gain partial products and sigma squared.
// Depends on nothing.
`default_nettype none

module dpnc_mul (
	input  wire logic        clk,
	input  wire logic [23:0] a,
	input  wire logic [23:0] b,
	output logic      [47:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

FILE: src/dpnc_div.sv
// Restoring divider for the confidence ratio: ref*2^16 / (ref+var), rounded half up.
// One quotient bit per cycle, 17 bits, then a rounding step.
// Depends on dpnc_pkg.
`default_nettype none

module dpnc_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dpnc_pkg::div_ctrl_t ctrl,
	input  wire logic      [47:0] ref_val,
	input  wire logic      [47:0] var_val,
	output dpnc_pkg::div_stat_t   stat,
	output logic           [16:0] quot
);

	localparam int unsigned STEPS = 17;

	typedef enum logic [1:0] {D_IDLE, D_STEP, D_ROUND} dstate_t;

	dstate_t     state_q;
	logic [48:0] den_q;
	logic [48:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        first_q;
	logic        done_q;

	logic [49:0] sh;
	logic        ge;
	logic [49:0] dbl;
	logic [49:0] diff;

	always_comb begin
		dbl  = {rem_q, 1'b0};
		// quotient bit 16 compares ref itself, later bits the doubled remainder
		sh   = first_q ? {1'b0, rem_q} : dbl;
		ge   = sh >= {1'b0, den_q};
		diff = sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (ctrl.start) begin
						state_q <= D_STEP;
						cnt_q   <= '0;
						first_q <= 1'b1;
					end
				end
				D_STEP: begin
					first_q <= 1'b0;
					if (cnt_q == 5'(STEPS - 1)) begin
						state_q <= D_ROUND;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				D_ROUND: begin
					state_q <= D_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (ctrl.start) begin
					den_q <= {1'b0, ref_val} + {1'b0, var_val};
					rem_q <= {1'b0, ref_val};
					quo_q <= '0;
				end
			end
			D_STEP: begin
				rem_q <= ge ? diff[48:0] : sh[48:0];
				quo_q <= {quo_q[15:0], ge};
			end
			D_ROUND: begin
				if (dbl >= {1'b0, den_q}) begin
					quo_q <= quo_q + 17'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = done_q;
	assign quot      = quo_q;

endmodule

`default_nettype wire

FILE: src/dpnc_checker.sv
// Port-level assertions for depth_pixel_noise_confidence, bound to the top level.
// Depends on dpnc_pkg.
`default_nettype none

module dpnc_assertions (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire dpnc_pkg::in_beat_t              in_data,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire dpnc_pkg::out_beat_t             out_data,
	input  wire logic                            cfg_wen,
	input  wire logic [dpnc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dpnc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// a result beat is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before accept");

	// one pixel at a time: busy straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while busy");

	// rejected pixels carry no depth, variance or confidence
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.pixel_class != dpnc_pkg::CLS_VALID) |->
		(out_data.clean_depth == '0) && (out_data.noise_variance == '0) &&
		(out_data.confidence == '0))
		else $error("invalid pixel with non-zero payload");

	// confidence never exceeds one, valid and non-finite counts never exceed pixels seen
	a_counts_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.confidence <= dpnc_pkg::CONF_ONE) &&
		(out_data.valid_count <= out_data.pixels_seen) &&
		(out_data.nonfinite_count <= out_data.pixels_seen))
		else $error("confidence or frame counters out of range");

endmodule

bind depth_pixel_noise_confidence dpnc_assertions u_dpnc_assertions (.*);

`default_nettype wire
